### sv/lmpc_pkg.sv
// ----------------------------------------------------------------------------
// lmpc_pkg
// Shared types and constants for the LED mode pattern controller: mode codes,
// configuration register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package lmpc_pkg;

    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int IVL_W      = 10;
    localparam int BYTE_W     = 8;
    localparam int LED_W      = 3;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_CHASE   = 2'd1,
        MODE_ALL_ON  = 2'd2,
        MODE_BREATHE = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_CHASE_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_INTERVAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_HOLDOFF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_HOLDOFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP      = 3'd5;

    localparam logic [IVL_W-1:0]  RST_CHASE_INTERVAL = 10'd200;
    localparam logic [IVL_W-1:0]  RST_FADE_INTERVAL  = 10'd15;
    localparam logic [IVL_W-1:0]  RST_MODE_HOLDOFF   = 10'd300;
    localparam logic [IVL_W-1:0]  RST_RESET_HOLDOFF  = 10'd200;
    localparam logic [BYTE_W-1:0] RST_PWM_PERIOD     = 8'd10;
    localparam logic [BYTE_W-1:0] RST_FADE_STEP      = 8'd5;

    localparam logic [LED_W-1:0] LEDS_OFF = 3'b000;
    localparam logic [LED_W-1:0] LEDS_ON  = 3'b111;
    localparam logic [BYTE_W-1:0] BRIGHT_MAX = 8'd255;

    typedef struct packed {
        logic [IVL_W-1:0]  chase_interval;
        logic [IVL_W-1:0]  fade_interval;
        logic [IVL_W-1:0]  mode_holdoff;
        logic [IVL_W-1:0]  reset_holdoff;
        logic [BYTE_W-1:0] pwm_period;
        logic [BYTE_W-1:0] fade_step;
    } cfg_t;

endpackage

### sv/lmpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lmpc_cfg_regs
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module lmpc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [lmpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lmpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lmpc_pkg::cfg_t                    cfg
);

    lmpc_pkg::cfg_t cfg_reg;
    lmpc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                lmpc_pkg::CFG_CHASE_INTERVAL: cfg_next.chase_interval = cfg_data;
                lmpc_pkg::CFG_FADE_INTERVAL:  cfg_next.fade_interval  = cfg_data;
                lmpc_pkg::CFG_MODE_HOLDOFF:   cfg_next.mode_holdoff   = cfg_data;
                lmpc_pkg::CFG_RESET_HOLDOFF:  cfg_next.reset_holdoff  = cfg_data;
                lmpc_pkg::CFG_PWM_PERIOD:     cfg_next.pwm_period     = cfg_data[7:0];
                lmpc_pkg::CFG_FADE_STEP:      cfg_next.fade_step      = cfg_data[7:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chase_interval <= lmpc_pkg::RST_CHASE_INTERVAL;
            cfg_reg.fade_interval  <= lmpc_pkg::RST_FADE_INTERVAL;
            cfg_reg.mode_holdoff   <= lmpc_pkg::RST_MODE_HOLDOFF;
            cfg_reg.reset_holdoff  <= lmpc_pkg::RST_RESET_HOLDOFF;
            cfg_reg.pwm_period     <= lmpc_pkg::RST_PWM_PERIOD;
            cfg_reg.fade_step      <= lmpc_pkg::RST_FADE_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/lmpc_tick_logic.sv
// ----------------------------------------------------------------------------
// lmpc_tick_logic
// Per-tick state of the controller: mode, chase, fade and pwm state plus the
// saturating elapsed counters. Computes the next LED bits and mode in one pass.
// ----------------------------------------------------------------------------
module lmpc_tick_logic #(
    parameter int ELAPSED_WIDTH = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tick,
    input  logic                            mode_btn,
    input  logic                            reset_btn,
    input  lmpc_pkg::cfg_t                  cfg,
    output logic [lmpc_pkg::LED_W-1:0]      led_next,
    output lmpc_pkg::mode_t                 mode_next
);

    localparam int CMP_W = (ELAPSED_WIDTH > lmpc_pkg::IVL_W) ? ELAPSED_WIDTH
                                                             : lmpc_pkg::IVL_W;
    localparam int PROD_W = 2 * lmpc_pkg::BYTE_W + 1;

    lmpc_pkg::mode_t                 mode_reg;
    logic [lmpc_pkg::BYTE_W-1:0]     bright_reg;
    logic                            falling_reg;
    logic [1:0]                      pos_reg;
    logic [ELAPSED_WIDTH-1:0]        chase_el_reg;
    logic [ELAPSED_WIDTH-1:0]        fade_el_reg;
    logic [ELAPSED_WIDTH-1:0]        mode_el_reg;
    logic [ELAPSED_WIDTH-1:0]        reset_el_reg;
    logic [lmpc_pkg::BYTE_W-1:0]     phase_reg;
    logic [lmpc_pkg::LED_W-1:0]      led_reg;

    lmpc_pkg::mode_t                 mode_v;
    logic [lmpc_pkg::BYTE_W-1:0]     bright_v;
    logic                            falling_v;
    logic [1:0]                      pos_v;
    logic [ELAPSED_WIDTH-1:0]        chase_el_v;
    logic [ELAPSED_WIDTH-1:0]        fade_el_v;
    logic [ELAPSED_WIDTH-1:0]        mode_el_v;
    logic [ELAPSED_WIDTH-1:0]        reset_el_v;
    logic [lmpc_pkg::LED_W-1:0]      led_v;

    logic [ELAPSED_WIDTH-1:0]        chase_el_next;
    logic [ELAPSED_WIDTH-1:0]        fade_el_next;
    logic [ELAPSED_WIDTH-1:0]        mode_el_next;
    logic [ELAPSED_WIDTH-1:0]        reset_el_next;
    logic [lmpc_pkg::BYTE_W-1:0]     phase_next;

    logic                            rst_evt;
    logic                            mode_evt;
    logic signed [lmpc_pkg::IVL_W-1:0] nb;
    logic [lmpc_pkg::BYTE_W:0]       phase_inc;
    logic [PROD_W-1:0]               duty_lhs;
    logic [PROD_W-1:0]               duty_rhs;

    function automatic logic [ELAPSED_WIDTH-1:0] sat_inc(input logic [ELAPSED_WIDTH-1:0] v);
        logic [ELAPSED_WIDTH-1:0] r;
        r = (v == {ELAPSED_WIDTH{1'b1}}) ? v : v + 1'b1;
        return r;
    endfunction

    always_comb
    begin
        mode_v     = mode_reg;
        bright_v   = bright_reg;
        falling_v  = falling_reg;
        pos_v      = pos_reg;
        chase_el_v = chase_el_reg;
        fade_el_v  = fade_el_reg;
        mode_el_v  = mode_el_reg;
        reset_el_v = reset_el_reg;
        led_v      = led_reg;
        nb         = '0;
        duty_rhs   = '0;

        phase_inc = {1'b0, phase_reg} + 1'b1;
        // phase < floor(b*p/255)  <=>  (phase+1)*255 <= b*p
        duty_lhs  = {phase_inc, {lmpc_pkg::BYTE_W{1'b0}}} - PROD_W'(phase_inc);

        rst_evt  = reset_btn && (CMP_W'(reset_el_reg) >= CMP_W'(cfg.reset_holdoff));
        mode_evt = mode_btn && (CMP_W'(mode_el_reg) >= CMP_W'(cfg.mode_holdoff));

        if (rst_evt)
        begin
            reset_el_v = '0;
            mode_v     = lmpc_pkg::MODE_OFF;
            bright_v   = '0;
            falling_v  = 1'b0;
            pos_v      = 2'd0;
            led_v      = lmpc_pkg::LEDS_OFF;
        end
        else
        begin
            if (mode_evt)
            begin
                mode_el_v  = '0;
                mode_v     = lmpc_pkg::mode_t'(mode_reg + 2'd1);
                bright_v   = '0;
                falling_v  = 1'b0;
                pos_v      = 2'd0;
                chase_el_v = '0;
                fade_el_v  = '0;
                led_v      = (mode_v == lmpc_pkg::MODE_ALL_ON) ? lmpc_pkg::LEDS_ON
                                                               : lmpc_pkg::LEDS_OFF;
            end

            case (mode_v)
                lmpc_pkg::MODE_CHASE:
                begin
                    if (CMP_W'(chase_el_v) >= CMP_W'(cfg.chase_interval))
                    begin
                        chase_el_v = '0;
                        case (pos_v)
                            2'd0:    begin led_v = 3'b001; pos_v = 2'd1; end
                            2'd1:    begin led_v = 3'b010; pos_v = 2'd2; end
                            2'd2:    begin led_v = 3'b100; pos_v = 2'd0; end
                            default: begin led_v = lmpc_pkg::LEDS_OFF; pos_v = 2'd1; end
                        endcase
                    end
                end
                lmpc_pkg::MODE_BREATHE:
                begin
                    if (CMP_W'(fade_el_v) >= CMP_W'(cfg.fade_interval))
                    begin
                        fade_el_v = '0;
                        nb = falling_v ? ({2'b00, bright_v} - {2'b00, cfg.fade_step})
                                       : ({2'b00, bright_v} + {2'b00, cfg.fade_step});
                        if (nb <= 10'sd0)
                        begin
                            bright_v  = '0;
                            falling_v = 1'b0;
                        end
                        else if (nb >= 10'sd255)
                        begin
                            bright_v  = lmpc_pkg::BRIGHT_MAX;
                            falling_v = 1'b1;
                        end
                        else
                        begin
                            bright_v = nb[lmpc_pkg::BYTE_W-1:0];
                        end
                    end
                    duty_rhs = PROD_W'(bright_v * cfg.pwm_period);
                    led_v    = (duty_lhs <= duty_rhs) ? lmpc_pkg::LEDS_ON
                                                      : lmpc_pkg::LEDS_OFF;
                end
                default:
                begin
                    led_v = led_v;
                end
            endcase
        end

        chase_el_next = sat_inc(chase_el_v);
        fade_el_next  = sat_inc(fade_el_v);
        mode_el_next  = sat_inc(mode_el_v);
        reset_el_next = sat_inc(reset_el_v);
        phase_next    = (phase_inc >= {1'b0, cfg.pwm_period}) ? '0
                                                              : phase_inc[lmpc_pkg::BYTE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= lmpc_pkg::MODE_OFF;
            bright_reg   <= '0;
            falling_reg  <= 1'b0;
            pos_reg      <= 2'd0;
            chase_el_reg <= '0;
            fade_el_reg  <= '0;
            mode_el_reg  <= '0;
            reset_el_reg <= '0;
            phase_reg    <= '0;
            led_reg      <= lmpc_pkg::LEDS_OFF;
        end
        else if (tick)
        begin
            mode_reg     <= mode_v;
            bright_reg   <= bright_v;
            falling_reg  <= falling_v;
            pos_reg      <= pos_v;
            chase_el_reg <= chase_el_next;
            fade_el_reg  <= fade_el_next;
            mode_el_reg  <= mode_el_next;
            reset_el_reg <= reset_el_next;
            phase_reg    <= phase_next;
            led_reg      <= led_v;
        end
    end

    assign led_next  = led_v;
    assign mode_next = mode_v;

endmodule

### sv/led_mode_pattern_controller.sv
// ----------------------------------------------------------------------------
// led_mode_pattern_controller
// Four-mode LED controller (off, chase, all on, breathing pwm) driven by one
// millisecond tick transaction per input, one result transaction per tick.
//
//   channel   direction   handshake                 payload
//   in        sink        in_valid / in_stall       mode_pressed, reset_pressed
//   out       source      out_valid / out_stall     led_levels, current_mode
//   cfg       sink        cfg_write_en              cfg_index, cfg_data
//
// one tick per clock sustained while out is not stalled; a result reaches the
// result register after its input is accepted into the input register, set by
// the single-pass tick logic between them. reset clears the valid flags and
// the tick state and loads the default configuration. a stall on out holds the
// result register and backs up into in_stall only when both registers are full.
// ----------------------------------------------------------------------------
module led_mode_pattern_controller #(
    parameter int ELAPSED_WIDTH = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode_pressed,
    input  logic                             reset_pressed,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       led_levels,
    output logic [1:0]                       current_mode,
    input  logic                             cfg_write_en,
    input  logic [lmpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lmpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lmpc_pkg::cfg_t                cfg;
    logic                          in_valid_reg;
    logic                          mode_p_reg;
    logic                          reset_p_reg;
    logic                          out_valid_reg;
    logic [lmpc_pkg::LED_W-1:0]    led_out_reg;
    lmpc_pkg::mode_t               mode_out_reg;
    logic                          advance;
    logic                          tick;
    logic [lmpc_pkg::LED_W-1:0]    led_next;
    lmpc_pkg::mode_t               mode_next;

    // result register free or being emptied this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign tick     = advance && in_valid_reg;
    assign in_stall = in_valid_reg && !advance;

    lmpc_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    lmpc_tick_logic #(
        .ELAPSED_WIDTH (ELAPSED_WIDTH)
    ) u_tick (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .mode_btn  (mode_p_reg),
        .reset_btn (reset_p_reg),
        .cfg       (cfg),
        .led_next  (led_next),
        .mode_next (mode_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_p_reg  <= mode_pressed;
            reset_p_reg <= reset_pressed;
        end
        if (tick)
        begin
            led_out_reg  <= led_next;
            mode_out_reg <= mode_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign led_levels   = led_out_reg;
    assign current_mode = mode_out_reg;

endmodule
